[rtl/sotq_pkg.sv]
// Shared constants, codes and the wraparound time compare for the timer queue.
package sotq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int TIME_W     = 64;
  localparam int DELAY_W    = 32;
  localparam int KIND_W     = 3;
  localparam int OP_W       = 2;

  localparam logic [TIME_W-1:0] HALF_RANGE = {1'b0, {(TIME_W-1){1'b1}}};

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_EXPIRE = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_ARMED      = 3'd0,
    K_ARMED_HEAD = 3'd1,
    K_CANCELLED  = 3'd2,
    K_NOT_ARMED  = 3'd3,
    K_EXPIRED    = 3'd4,
    K_RESTART    = 3'd5,
    K_EMPTY      = 3'd6,
    K_FAULT      = 3'd7
  } kind_t;

  // True when a lies before b on the wrapping 64-bit time line.
  function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] ba;
    logic [TIME_W-1:0] ab;
    begin
      ba = b - a;
      ab = a - b;
      earlier = ((a < b) && (ba < HALF_RANGE)) || ((a > b) && (ab > HALF_RANGE));
    end
  endfunction

endpackage

[rtl/sotq_req_if.sv]
// Request channel: one timer operation word.
interface sotq_req_if import sotq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SLOT_W-1:0]   timer_id;
  logic [DELAY_W-1:0]  delay_ms;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, operation, timer_id, delay_ms, now_ms, input ready);
  modport sink   (input valid, operation, timer_id, delay_ms, now_ms, output ready);
endinterface

[rtl/sotq_rsp_if.sv]
// Response channel: one result word per reported event.
interface sotq_rsp_if import sotq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot;
  logic [DELAY_W-1:0]  restart_delay;
  logic                last;

  modport source (output valid, kind, slot, restart_delay, last, input ready);
  modport sink   (input valid, kind, slot, restart_delay, last, output ready);
endinterface

[rtl/sotq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/sorted_oneshot_timer_queue.sv]
// Sorted one-shot timer queue: linked list of timers held in two RAMs.
// Fault, not armed and a start on an empty list are answered straight away; a start that
// becomes the new head skips the walk, other starts and cancels away from the head walk the
// list; an expire gives one word per timer that is due, then restart, fault or list empty.
// One operation at a time: the next is accepted in the cycle after its last word is loaded, and
// a stall delays the load. Sync reset clears armed bits, head and count, not the RAMs.
module sorted_oneshot_timer_queue import sotq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sotq_req_if.sink   req,
  sotq_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_ST_HEAD, S_ST_RN, S_ST_RL, S_ST_CMP, S_ST_LINK1, S_ST_LINK2,
    S_CN_HEAD, S_CN_RN, S_CN_RL, S_CN_RID, S_CN_DONE, S_EX_HEAD, S_EX_CMP, S_EMIT
  } state_t;

  state_t                state;
  logic [NUM_TIMERS-1:0] armed;
  logic [SLOT_W-1:0]     head_slot;
  logic [CNT_W-1:0]      list_count;
  logic [SLOT_W-1:0]     id_r;
  logic [SLOT_W-1:0]     cur;
  logic [SLOT_W-1:0]     nxt;
  logic [CNT_W-1:0]      steps;
  logic [TIME_W-1:0]     wake_new;
  logic [TIME_W-1:0]     now_r;
  logic [TIME_W-1:0]     now_plus1;
  logic [DELAY_W-1:0]    delay_r;

  kind_t                 res_kind;
  logic [SLOT_W-1:0]     res_slot;
  logic [DELAY_W-1:0]    res_delay;
  logic                  res_last;

  logic                  rsp_valid;
  kind_t                 rsp_kind;
  logic [SLOT_W-1:0]     rsp_slot;
  logic [DELAY_W-1:0]    rsp_delay;
  logic                  rsp_last;

  logic                  wt_we;
  logic [SLOT_W-1:0]     wt_waddr;
  logic [TIME_W-1:0]     wt_wdata;
  logic [SLOT_W-1:0]     wt_raddr;
  logic [TIME_W-1:0]     wt_rdata;
  logic                  nl_we;
  logic [SLOT_W-1:0]     nl_waddr;
  logic [SLOT_W-1:0]     nl_wdata;
  logic [SLOT_W-1:0]     nl_raddr;
  logic [SLOT_W-1:0]     nl_rdata;

  logic                  accept;
  logic                  can_emit;
  logic                  id_bad;
  logic                  start_ok;
  logic [TIME_W-1:0]     gap;
  logic [CNT_W-1:0]      count_dec;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign can_emit  = !rsp_valid || rsp.ready;
  assign id_bad    = ({1'b0, req.timer_id} >= (SLOT_W + 1)'(NUM_TIMERS));
  assign start_ok  = (req.operation == OP_START) && !id_bad && !armed[req.timer_id];
  assign gap       = wt_rdata - now_r;
  assign count_dec = (list_count != '0) ? list_count - 1'b1 : list_count;

  sotq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_wake_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  sotq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_TIMERS)) u_link_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (nl_raddr),
    .rdata (nl_rdata)
  );

  // RAM access for each step of the list walks.
  always_comb begin
    wt_we    = 1'b0;
    wt_waddr = req.timer_id;
    wt_wdata = req.now_ms + TIME_W'(req.delay_ms);
    wt_raddr = head_slot;
    nl_we    = 1'b0;
    nl_waddr = id_r;
    nl_wdata = head_slot;
    nl_raddr = cur;
    unique case (state)
      S_IDLE: begin
        if (accept && req.operation == OP_START && !id_bad && !armed[req.timer_id]) begin
          wt_we = 1'b1;
          if (list_count == '0) begin
            nl_we    = 1'b1;
            nl_waddr = req.timer_id;
          end
        end
        if (accept && req.operation == OP_CANCEL) begin
          nl_raddr = req.timer_id;
        end
      end
      S_ST_HEAD: begin
        nl_we = earlier(wake_new, wt_rdata);
      end
      S_ST_RL: begin
        wt_raddr = nl_rdata;
      end
      S_ST_LINK1: begin
        nl_we    = 1'b1;
        nl_wdata = nxt;
      end
      S_ST_LINK2: begin
        nl_we    = 1'b1;
        nl_waddr = cur;
        nl_wdata = id_r;
      end
      S_CN_RL: begin
        nl_raddr = id_r;
      end
      S_CN_RID: begin
        nl_we    = 1'b1;
        nl_waddr = cur;
        nl_wdata = nl_rdata;
      end
      S_EX_HEAD: begin
        nl_raddr = head_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      armed      <= '0;
      head_slot  <= '0;
      list_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_EMIT && can_emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            id_r      <= req.timer_id;
            delay_r   <= req.delay_ms;
            now_r     <= req.now_ms;
            now_plus1 <= req.now_ms + TIME_W'(1);
            wake_new  <= req.now_ms + TIME_W'(req.delay_ms);
            cur       <= head_slot;
            steps     <= CNT_W'(1);
            res_slot  <= req.timer_id;
            res_delay <= (start_ok && list_count == '0) ? req.delay_ms : '0;
            res_last  <= 1'b1;
            unique case (req.operation)
              OP_START: begin
                if (id_bad || armed[req.timer_id]) begin
                  res_kind <= K_FAULT;
                  state    <= S_EMIT;
                end else begin
                  armed[req.timer_id] <= 1'b1;
                  if (list_count == '0) begin
                    head_slot  <= req.timer_id;
                    list_count <= list_count + 1'b1;
                    res_kind   <= K_ARMED_HEAD;
                    state      <= S_EMIT;
                  end else begin
                    state <= S_ST_HEAD;
                  end
                end
              end
              OP_CANCEL: begin
                if (id_bad || !armed[req.timer_id]) begin
                  res_kind <= K_NOT_ARMED;
                  state    <= S_EMIT;
                end else begin
                  armed[req.timer_id] <= 1'b0;
                  if (head_slot == req.timer_id) begin
                    state <= S_CN_HEAD;
                  end else if (list_count > CNT_W'(1)) begin
                    state <= S_CN_RN;
                  end else begin
                    state <= S_CN_DONE;
                  end
                end
              end
              OP_EXPIRE: begin
                state <= S_EX_HEAD;
              end
              default: begin
                // The unused operation code is dropped without a response.
              end
            endcase
          end
        end
        S_ST_HEAD: begin
          if (earlier(wake_new, wt_rdata)) begin
            head_slot  <= id_r;
            list_count <= list_count + 1'b1;
            res_kind   <= K_ARMED_HEAD;
            res_delay  <= delay_r;
            state      <= S_EMIT;
          end else begin
            state <= S_ST_RN;
          end
        end
        S_ST_RN: begin
          state <= S_ST_RL;
        end
        S_ST_RL: begin
          nxt   <= nl_rdata;
          state <= (steps < list_count) ? S_ST_CMP : S_ST_LINK1;
        end
        S_ST_CMP: begin
          // Equal wake times keep arrival order: insert only before a later entry.
          if (earlier(wake_new, wt_rdata)) begin
            state <= S_ST_LINK1;
          end else begin
            cur   <= nxt;
            steps <= steps + 1'b1;
            state <= S_ST_RN;
          end
        end
        S_ST_LINK1: begin
          state <= S_ST_LINK2;
        end
        S_ST_LINK2: begin
          list_count <= list_count + 1'b1;
          res_kind   <= K_ARMED;
          state      <= S_EMIT;
        end
        S_CN_HEAD: begin
          head_slot <= nl_rdata;
          state     <= S_CN_DONE;
        end
        S_CN_RN: begin
          state <= S_CN_RL;
        end
        S_CN_RL: begin
          if (nl_rdata == id_r) begin
            state <= S_CN_RID;
          end else begin
            cur   <= nl_rdata;
            steps <= steps + 1'b1;
            state <= ((steps + 1'b1) < list_count) ? S_CN_RN : S_CN_DONE;
          end
        end
        S_CN_RID: begin
          state <= S_CN_DONE;
        end
        S_CN_DONE: begin
          list_count <= count_dec;
          if (count_dec == '0) begin
            head_slot <= '0;
          end
          res_kind <= K_CANCELLED;
          state    <= S_EMIT;
        end
        S_EX_HEAD: begin
          if (list_count == '0) begin
            head_slot <= '0;
            res_kind  <= K_EMPTY;
            res_slot  <= '0;
            res_delay <= '0;
            res_last  <= 1'b1;
            state     <= S_EMIT;
          end else begin
            state <= S_EX_CMP;
          end
        end
        S_EX_CMP: begin
          res_slot <= head_slot;
          if (earlier(wt_rdata, now_plus1)) begin
            armed[head_slot] <= 1'b0;
            head_slot        <= nl_rdata;
            list_count       <= list_count - 1'b1;
            res_kind         <= K_EXPIRED;
            res_delay        <= '0;
            res_last         <= 1'b0;
          end else if (gap[TIME_W-1:DELAY_W] != '0) begin
            res_kind  <= K_FAULT;
            res_delay <= '0;
            res_last  <= 1'b1;
          end else begin
            res_kind  <= K_RESTART;
            res_delay <= gap[DELAY_W-1:0];
            res_last  <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_emit) begin
            rsp_kind  <= res_kind;
            rsp_slot  <= res_slot;
            rsp_delay <= res_delay;
            rsp_last  <= res_last;
            state     <= res_last ? S_IDLE : S_EX_HEAD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.kind          = rsp_kind;
  assign rsp.slot          = rsp_slot;
  assign rsp.restart_delay = rsp_delay;
  assign rsp.last          = rsp_last;

  // Between operations every armed timer is on the list and nothing else is.
  a_count_matches_armed: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(armed) == int'(list_count)))
    else $error("list count differs from number of armed timers");

  // An empty list always leaves the head pointer at slot zero.
  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && list_count == '0) |-> (head_slot == '0))
    else $error("head slot not cleared on empty list");

  // Every valid operation keeps the block busy until its response is queued.
  a_op_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.operation == OP_START || req.operation == OP_CANCEL ||
                req.operation == OP_EXPIRE)) |=> (state != S_IDLE))
    else $error("operation accepted without entering a busy state");

  // A response is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && rsp_valid && !rsp.ready) |=> (state == S_EMIT))
    else $error("response left the emit state while output was stalled");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for the sorted one-shot timer queue: directed and random timer traffic, predicted and checked.
module tb;
  import sotq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET    = 280;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 200;
  localparam int MAX_PRINTED    = 40;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  id;
    logic [DELAY_W-1:0] delay;
    logic [TIME_W-1:0]  now;
  } timer_req_t;

  typedef struct {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] delay;
    logic               last;
  } timer_word_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sotq_req_if req_ch ();
  sotq_rsp_if rsp_ch ();

  sorted_oneshot_timer_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the timer list.
  logic [TIME_W-1:0] wake_q [NUM_TIMERS];
  logic              armed_q [NUM_TIMERS];
  logic [SLOT_W-1:0] link_q [NUM_TIMERS];
  logic [SLOT_W-1:0] head_q;
  int                count_q;

  timer_req_t  pending_q [$];
  timer_word_t due_words_q [$];

  int n_errors = 0;
  int n_items = 0;
  int n_directed = 0;
  int n_accepted = 0;
  int n_words = 0;
  int kind_seen [8];
  logic [TIME_W-1:0] wall_ms;
  logic hold_req = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // True when wake time a falls before b on the wrapping time line.
  function automatic logic wakes_before(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] fwd;
    logic [TIME_W-1:0] back;
    fwd  = b - a;
    back = a - b;
    if (a < b) return fwd < HALF_RANGE;
    if (a > b) return back > HALF_RANGE;
    return 1'b0;
  endfunction

  function automatic void add_word(input kind_t k, input logic [SLOT_W-1:0] s,
                                   input logic [DELAY_W-1:0] d);
    timer_word_t w;
    w.kind  = k;
    w.slot  = s;
    w.delay = d;
    w.last  = 1'b0;
    due_words_q.push_back(w);
  endfunction

  function automatic void predict_timer_op(input timer_req_t r);
    int                base;
    int                step;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] h;
    logic [TIME_W-1:0] w;
    logic [TIME_W-1:0] gap;
    logic              closed;
    base = due_words_q.size();
    case (r.op)
      OP_START: begin
        if (armed_q[r.id]) begin
          add_word(K_FAULT, r.id, '0);
        end else begin
          w = r.now + {32'd0, r.delay};
          wake_q[r.id]  = w;
          armed_q[r.id] = 1'b1;
          if (count_q == 0 || wakes_before(w, wake_q[head_q])) begin
            link_q[r.id] = head_q;
            head_q = r.id;
            count_q++;
            add_word(K_ARMED_HEAD, r.id, r.delay);
          end else begin
            // Walk past every entry that does not wake later than the new one.
            cur = head_q;
            for (step = 1; step < count_q; step++) begin
              if (wakes_before(w, wake_q[link_q[cur]])) break;
              cur = link_q[cur];
            end
            link_q[r.id] = link_q[cur];
            link_q[cur]  = r.id;
            count_q++;
            add_word(K_ARMED, r.id, '0);
          end
        end
      end
      OP_CANCEL: begin
        if (!armed_q[r.id]) begin
          add_word(K_NOT_ARMED, r.id, '0);
        end else begin
          armed_q[r.id] = 1'b0;
          if (head_q == r.id) begin
            head_q = link_q[r.id];
          end else begin
            cur = head_q;
            for (step = 1; step < count_q; step++) begin
              if (link_q[cur] == r.id) begin
                link_q[cur] = link_q[r.id];
                break;
              end
              cur = link_q[cur];
            end
          end
          if (count_q > 0) count_q--;
          if (count_q == 0) head_q = '0;
          add_word(K_CANCELLED, r.id, '0);
        end
      end
      OP_EXPIRE: begin
        closed = 1'b0;
        while (count_q > 0 && !closed) begin
          h = head_q;
          if (wakes_before(wake_q[h], r.now + 64'd1)) begin
            armed_q[h] = 1'b0;
            head_q = link_q[h];
            count_q--;
            add_word(K_EXPIRED, h, '0);
          end else begin
            gap = wake_q[h] - r.now;
            if (gap > 64'h0000_0000_FFFF_FFFF) add_word(K_FAULT, h, '0);
            else add_word(K_RESTART, h, gap[DELAY_W-1:0]);
            closed = 1'b1;
          end
        end
        if (!closed) begin
          head_q = '0;
          add_word(K_EMPTY, '0, '0);
        end
      end
      default: ;
    endcase
    if (due_words_q.size() > base) due_words_q[due_words_q.size()-1].last = 1'b1;
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] id,
                            input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] now);
    timer_req_t r;
    r.op    = op;
    r.id    = id;
    r.delay = delay;
    r.now   = now;
    pending_q.push_back(r);
    if (op != OP_UNUSED) n_items++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || req_ch.valid || due_words_q.size() != 0)
      @(negedge clk);
  endtask

  // One burst of traffic around the running wall clock. A fill round first
  // flushes the list and then arms every slot so that one expire pops them all.
  task automatic queue_round(input bit fill);
    int                n_ops;
    int                k;
    int                pick;
    logic [SLOT_W-1:0] id;
    logic [DELAY_W-1:0] dly;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(0, 19);
    if (pick == 0) wall_ms = {$urandom, $urandom};
    else if (pick == 1) wall_ms = wall_ms + HALF_RANGE;
    else if (pick == 2) wall_ms = wall_ms + {32'd0, $urandom};
    if (fill) begin
      wall_ms = wall_ms + (64'd1 << 33);
      queue_item(OP_EXPIRE, SLOT_W'($urandom), $urandom, wall_ms);
    end
    n_ops = fill ? NUM_TIMERS : $urandom_range(1, 10);
    for (k = 0; k < n_ops; k++) begin
      pick = fill ? 0 : $urandom_range(0, 19);
      id   = fill ? k[SLOT_W-1:0] : SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
      if (!fill && $urandom_range(0, 7) == 0) dly = $urandom;
      else dly = $urandom_range(0, 3000);
      if (pick < 13) queue_item(OP_START, id, dly, wall_ms);
      else if (pick < 17) queue_item(OP_CANCEL, id, $urandom, wall_ms);
      else if (pick < 19) queue_item(OP_EXPIRE, id, $urandom, wall_ms);
      else queue_item(OP_UNUSED, id, $urandom, {$urandom, $urandom});
      wall_ms = wall_ms + $urandom_range(0, 40);
    end
    if (fill) begin
      wall_ms = wall_ms + 64'd4000;
      queue_item(OP_EXPIRE, SLOT_W'($urandom), $urandom, wall_ms);
    end else begin
      n_ops = $urandom_range(1, 3);
      for (k = 0; k < n_ops; k++) begin
        // Now and then time steps backward, which can push the next wake
        // time beyond what the platform timer can hold.
        if ($urandom_range(0, 11) == 0) begin
          t = wall_ms - ({32'd0, $urandom} << $urandom_range(0, 16));
        end else begin
          wall_ms = wall_ms + $urandom_range(0, 2500);
          t = wall_ms;
        end
        queue_item(OP_EXPIRE, SLOT_W'($urandom), $urandom, t);
      end
    end
  endtask

  // Request driver: bursts of random length with random gaps.
  always @(posedge clk) begin : drive_req
    int         burst_left;
    int         gap_left;
    timer_req_t nxt;
    logic       offer;
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        req_ch.operation <= nxt.op;
        req_ch.timer_id  <= nxt.id;
        req_ch.delay_ms  <= nxt.delay;
        req_ch.now_ms    <= nxt.now;
        offer = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      req_ch.valid <= offer;
    end
  end

  // Result receiver: a randomly chosen stall pattern, plus one long hold-off.
  always @(posedge clk) begin : drive_rsp_ready
    int       rx_cycle;
    int       hold_left;
    bit       hold_done;
    rx_mode_t rx_mode;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rx_mode   = RX_OPEN;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_LIGHT:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY:  rsp_ch.ready <= ($urandom_range(0, 9) < 3);
          default:   rsp_ch.ready <= rx_cycle[2];
        endcase
      end
    end
  end

  // Predicts each accepted request, then checks each accepted result word.
  always @(posedge clk) begin : check_words
    timer_req_t  seen;
    timer_word_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.op    = req_ch.operation;
        seen.id    = req_ch.timer_id;
        seen.delay = req_ch.delay_ms;
        seen.now   = req_ch.now_ms;
        predict_timer_op(seen);
        n_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_words++;
        kind_seen[rsp_ch.kind]++;
        if (due_words_q.size() == 0) begin
          report_mismatch("word with nothing expected, kind", rsp_ch.kind, '0);
        end else begin
          want = due_words_q.pop_front();
          if (rsp_ch.kind !== want.kind) report_mismatch("kind", rsp_ch.kind, want.kind);
          if (rsp_ch.slot !== want.slot) report_mismatch("slot", rsp_ch.slot, want.slot);
          if (rsp_ch.restart_delay !== want.delay)
            report_mismatch("restart_delay", rsp_ch.restart_delay, want.delay);
          if (rsp_ch.last !== want.last) report_mismatch("last", rsp_ch.last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int rounds;
    for (i = 0; i < NUM_TIMERS; i++) begin
      wake_q[i]  = '0;
      armed_q[i] = 1'b0;
      link_q[i]  = '0;
    end
    for (i = 0; i < 8; i++) kind_seen[i] = 0;
    head_q  = '0;
    count_q = 0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_START;
    req_ch.timer_id  = '0;
    req_ch.delay_ms  = '0;
    req_ch.now_ms    = '0;
    rsp_ch.ready     = 1'b0;

    // Empty list, unarmed cancel, double start, equal wake times, cancels
    // at the middle and the head, the ignored code, a backward step that
    // overflows the restart delay, and a wake time that wraps past zero.
    queue_item(OP_EXPIRE, 4'd0, 32'd0, 64'd0);
    queue_item(OP_CANCEL, 4'd3, 32'd0, 64'd0);
    queue_item(OP_START, 4'd0, 32'd0, 64'd0);
    queue_item(OP_START, 4'd0, 32'd5, 64'd0);
    queue_item(OP_START, 4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_START, 4'd5, 32'd0, 64'd0);
    queue_item(OP_START, 4'd9, 32'd100, 64'd0);
    queue_item(OP_CANCEL, 4'd5, 32'd0, 64'd0);
    queue_item(OP_CANCEL, 4'd0, 32'd0, 64'd0);
    queue_item(OP_UNUSED, 4'hA, 32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5);
    queue_item(OP_EXPIRE, 4'd0, 32'd0, 64'd50);
    queue_item(OP_EXPIRE, 4'd0, 32'd0, 64'd200);
    queue_item(OP_START, 4'd7, 32'd10, 64'd1 << 40);
    queue_item(OP_EXPIRE, 4'd0, 32'd0, 64'h0000_0000_FFFF_FFFF);
    queue_item(OP_EXPIRE, 4'd0, 32'd0, (64'd1 << 40) + 64'd10);
    queue_item(OP_START, 4'd3, 32'd20, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_item(OP_START, 4'd4, 32'd5, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_item(OP_EXPIRE, 4'd0, 32'd0, 64'd2);
    queue_item(OP_CANCEL, 4'd3, 32'd0, 64'd0);
    queue_item(OP_CANCEL, 4'd3, 32'd0, 64'd0);
    n_directed = n_items;
    wall_ms = 64'd1000;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait_idle();
    // The receiver holds off while a full list is armed and drained.
    @(negedge clk);
    hold_req <= 1'b1;
    queue_round(1'b1);

    rounds = 0;
    while (n_items < ITEM_TARGET) begin
      rounds++;
      queue_round(rounds % 9 == 0);
      if (rounds % 5 == 0) wait_idle();
      while (pending_q.size() > 8) @(negedge clk);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_words_q.size() != 0)
      report_mismatch("words never delivered, count", '0, due_words_q.size());

    $display("Sent %0d requests (%0d directed, %0d accepted incl. ignored), checked %0d words.",
             n_items, n_directed, n_accepted, n_words);
    $display("Kinds: armed %0d head %0d cancel %0d unarmed %0d expired %0d restart %0d %s",
             kind_seen[K_ARMED], kind_seen[K_ARMED_HEAD], kind_seen[K_CANCELLED],
             kind_seen[K_NOT_ARMED], kind_seen[K_EXPIRED], kind_seen[K_RESTART],
             $sformatf("empty %0d fault %0d", kind_seen[K_EMPTY], kind_seen[K_FAULT]));
    if (n_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
